FILE: hdl/lmbc_pkg.sv
package lmbc_pkg;

    // Fixed field widths of the item and configuration ports.
    localparam int FUNC_W   = 4;
    localparam int MASK_W   = 32;
    localparam int IDX_W    = 5;
    localparam int TIME_W   = 16;
    localparam int WING_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int CFG_IDX_W = 2;

    // On-time written by the lamp-on commands, in microseconds.
    localparam logic [TIME_W-1:0] ON_TIME_US = 16'd1000;
    localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hff;

    // Command codes carried by func.
    typedef enum logic [FUNC_W-1:0] {
        F_REFRESH   = 4'd0,
        F_ROT_LEFT  = 4'd1,
        F_ROT_RIGHT = 4'd2,
        F_ON        = 4'd3,
        F_OFF       = 4'd4,
        F_SLOW      = 4'd5,
        F_FAST      = 4'd6,
        F_BLINK_OFF = 4'd7,
        F_SET_ONOFF = 4'd8,
        F_COMBINED  = 4'd9,
        F_SET_DUR   = 4'd10
    } t_func;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WING_VALID  = 2'd0,
        CFG_WING_INVERT = 2'd1,
        CFG_OUT_EN      = 2'd2
    } t_cfg_reg;

    // How a cell updates its on-time.
    typedef enum logic [1:0] {
        T_KEEP = 2'd0,
        T_SEL  = 2'd1,
        T_ALL  = 2'd2
    } t_time_op;

    // How a cell updates one blink bit.
    typedef enum logic [1:0] {
        B_KEEP = 2'd0,
        B_SET  = 2'd1,
        B_CLR  = 2'd2,
        B_ZERO = 2'd3
    } t_blink_op;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        t_time_op          time_op;
        logic [TIME_W-1:0] time_val;
        t_blink_op         slow_op;
        t_blink_op         fast_op;
        logic              rot_clr;
        logic              rot_down;
        logic              wrap;
        logic [TIME_W-1:0] wrap_val;
        logic [TIME_W-1:0] now;
        logic              slow_phase;
        logic              fast_phase;
    } t_cell_cmd;

    // Rotation link passed from cell to cell.
    typedef struct packed {
        logic              tok;
        logic              cv;
        logic [TIME_W-1:0] carry;
    } t_link;

endpackage

FILE: hdl/masked_lamp_bank_controller.sv
// Lamp bank controller: keeps an on-time and blink membership for each lamp
// and turns refresh items into output pin levels.
// Input channel: i_valid / o_ready carry one item (func and its fields); a
// transfer takes place when both are high. Output channel: o_valid / i_ready
// carry one result (o_lamp_levels, o_drive_mask) for every item.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 wing valid, 1 wing invert, 2 outputs enabled) with no wait.
// Sequence: a refresh or plain command goes from the input transfer through the
// command step and the final state into the output register. A rotation adds
// a scan, in which the carry walks the chain of lamp cells one cell per cycle,
// and a wrap step that returns it to the first selected lamp. One item is
// worked on at a time; o_ready is high whenever the controller is between
// items, so the next item may be taken while a result waits in the output
// register. When the receiver stalls, the finished result of the following
// item waits in its final state until the output register is free.
// Reset (synchronous, active low): all on-times zero, every lamp in the slow
// blink set, none in the fast set, configuration registers zero.
module masked_lamp_bank_controller #(
    parameter int NUM_LAMPS = 32,
    parameter int NUM_WINGS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lmbc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lmbc_pkg::WING_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lmbc_pkg::FUNC_W-1:0]   i_func,
    input  logic [lmbc_pkg::MASK_W-1:0]   i_lamp_mask,
    input  logic                          i_flag_on,
    input  logic                          i_flag_blink_slow,
    input  logic                          i_flag_blink_fast,
    input  logic [lmbc_pkg::IDX_W-1:0]    i_lamp_index,
    input  logic [lmbc_pkg::TIME_W-1:0]   i_duration,
    input  logic [lmbc_pkg::TIME_W-1:0]   i_now_us,
    input  logic                          i_slow_phase,
    input  logic                          i_fast_phase,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [lmbc_pkg::MASK_W-1:0]   o_lamp_levels,
    output logic [lmbc_pkg::MASK_W-1:0]   o_drive_mask
);
    import lmbc_pkg::*;

    localparam int CNT_W = $clog2(NUM_LAMPS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ROT  = 5'b00100,
        S_WRAP = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    // Configuration registers.
    logic [WING_W-1:0]  r_wing_valid;
    logic [WING_W-1:0]  r_wing_invert;
    logic               r_out_en;

    // Captured item.
    logic [FUNC_W-1:0]  r_func;
    logic [MASK_W-1:0]  r_mask;
    logic               r_flag_on;
    logic               r_flag_slow;
    logic               r_flag_fast;
    logic [IDX_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_dur;
    logic [TIME_W-1:0]  r_now;
    logic               r_sph;
    logic               r_fph;

    // Output register.
    logic               r_ovalid;
    logic [MASK_W-1:0]  r_levels;
    logic [MASK_W-1:0]  r_drive;

    logic               w_in_fire;
    logic               w_out_free;
    logic               w_is_rot;
    logic               w_set_dur;
    t_cell_cmd          w_cmd;
    t_link              w_inject;
    t_link              w_end;
    t_link              w_link [NUM_LAMPS];
    logic [NUM_LAMPS-1:0] w_sel;
    logic [NUM_LAMPS-1:0] w_lit;
    logic [MASK_W-1:0]  w_lit32;
    logic [MASK_W-1:0]  w_levels;
    logic [MASK_W-1:0]  w_drive;

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_fire  = i_valid && o_ready;
    assign w_out_free = !r_ovalid || i_ready;
    assign w_is_rot   = (r_func == F_ROT_LEFT) || (r_func == F_ROT_RIGHT);
    assign w_set_dur  = (r_func == F_SET_DUR);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wing_valid  <= '0;
            r_wing_invert <= '0;
            r_out_en      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_WING_VALID:  r_wing_valid  <= i_cfg_data;
                CFG_WING_INVERT: r_wing_invert <= i_cfg_data;
                CFG_OUT_EN:      r_out_en      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Capture the item on its transfer.
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_func      <= i_func;
            r_mask      <= i_lamp_mask;
            r_flag_on   <= i_flag_on;
            r_flag_slow <= i_flag_blink_slow;
            r_flag_fast <= i_flag_blink_fast;
            r_idx       <= i_lamp_index;
            r_dur       <= i_duration;
            r_now       <= i_now_us;
            r_sph       <= i_slow_phase;
            r_fph       <= i_fast_phase;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: if (w_in_fire) n_state = S_EXEC;
            S_EXEC: begin
                n_cnt   = '0;
                n_state = w_is_rot ? S_ROT : S_DONE;
            end
            S_ROT: begin
                if (r_cnt == CNT_W'(NUM_LAMPS - 2)) begin
                    n_state = S_WRAP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_WRAP: n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Command decode into the broadcast to the cells.
    always_comb begin
        w_cmd            = '0;
        w_cmd.time_op    = T_KEEP;
        w_cmd.slow_op    = B_KEEP;
        w_cmd.fast_op    = B_KEEP;
        w_cmd.now        = r_now;
        w_cmd.slow_phase = r_sph;
        w_cmd.fast_phase = r_fph;
        w_cmd.rot_down   = (r_func == F_ROT_LEFT);
        w_cmd.rot_clr    = (r_state == S_EXEC) && w_is_rot;
        w_cmd.wrap       = (r_state == S_WRAP) && w_end.cv;
        w_cmd.wrap_val   = w_end.carry;
        if (r_state == S_EXEC) begin
            unique case (t_func'(r_func))
                F_ON: begin
                    w_cmd.time_op  = T_SEL;
                    w_cmd.time_val = ON_TIME_US;
                end
                F_OFF: w_cmd.time_op = T_SEL;
                F_SLOW: begin
                    w_cmd.time_op = T_SEL;
                    w_cmd.slow_op = B_SET;
                    w_cmd.fast_op = B_CLR;
                end
                F_FAST: begin
                    w_cmd.time_op = T_SEL;
                    w_cmd.slow_op = B_CLR;
                    w_cmd.fast_op = B_SET;
                end
                F_BLINK_OFF: begin
                    w_cmd.slow_op = B_CLR;
                    w_cmd.fast_op = B_CLR;
                end
                F_SET_ONOFF: begin
                    w_cmd.time_op  = T_ALL;
                    w_cmd.time_val = ON_TIME_US;
                    w_cmd.slow_op  = B_ZERO;
                    w_cmd.fast_op  = B_ZERO;
                end
                F_COMBINED: begin
                    // Joining a blink set zeroes the on-time after the on flag.
                    w_cmd.time_op = T_SEL;
                    if (!r_flag_slow && !r_flag_fast && r_flag_on) begin
                        w_cmd.time_val = ON_TIME_US;
                    end
                    if (r_flag_slow) begin
                        w_cmd.slow_op = B_SET;
                        w_cmd.fast_op = B_CLR;
                    end else if (r_flag_fast) begin
                        w_cmd.slow_op = B_CLR;
                        w_cmd.fast_op = B_SET;
                    end else begin
                        w_cmd.slow_op = B_CLR;
                        w_cmd.fast_op = B_CLR;
                    end
                end
                F_SET_DUR: begin
                    w_cmd.time_op  = T_SEL;
                    w_cmd.time_val = r_dur;
                end
                default: ;
            endcase
        end
    end

    // The scan starts at the low end for rotate right, the high end for left.
    always_comb begin
        w_inject       = '0;
        w_inject.tok   = (r_state == S_EXEC) && w_is_rot;
    end

    assign w_end = w_cmd.rot_down ? w_link[0] : w_link[NUM_LAMPS-1];

    // Chain of lamp cells.
    for (genvar i = 0; i < NUM_LAMPS; i++) begin : g_cell
        if (i < MASK_W) begin : g_sel
            assign w_sel[i] = w_set_dur ? (r_idx == IDX_W'(i)) : r_mask[i];
        end else begin : g_nosel
            assign w_sel[i] = 1'b0;
        end

        lmbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_sel   (w_sel[i]),
            .i_lo    ((i == 0) ? w_inject : w_link[(i == 0) ? 0 : i - 1]),
            .i_hi    ((i == NUM_LAMPS - 1) ? w_inject
                                           : w_link[(i == NUM_LAMPS - 1) ? i : i + 1]),
            .o_link  (w_link[i]),
            .o_lit   (w_lit[i])
        );
    end

    for (genvar j = 0; j < MASK_W; j++) begin : g_lit
        if (j < NUM_LAMPS) begin : g_on
            assign w_lit32[j] = w_lit[j];
        end else begin : g_off
            assign w_lit32[j] = 1'b0;
        end
    end

    // Refresh result with outputs enabled: per valid wing, the lit byte, inverted on high-side wings.
    always_comb begin
        w_levels = '0;
        w_drive  = '0;
        if ((r_func == F_REFRESH) && r_out_en) begin
            for (int w = 0; w < WING_W; w++) begin
                if ((w < NUM_WINGS) && r_wing_valid[w]) begin
                    w_levels[w*BYTE_W +: BYTE_W] = r_wing_invert[w]
                        ? ~w_lit32[w*BYTE_W +: BYTE_W] : w_lit32[w*BYTE_W +: BYTE_W];
                    w_drive[w*BYTE_W +: BYTE_W]  = BYTE_MASK;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_levels <= w_levels;
            r_drive  <= w_drive;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_lamp_levels = r_levels;
    assign o_drive_mask  = r_drive;

`ifndef ASSERT_OFF
    // Every transfer starts the command step in the next cycle.
    a_fire_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == S_EXEC))
        else $error("input transfer not followed by the command step");

    // The rotation token has reached the far end of the chain at wrap time.
    a_wrap_tok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |-> w_end.tok)
        else $error("rotation token not at chain end when wrapping");

    // A result only appears from the final state.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the final state");

    // Undriven bytes never carry a level.
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((r_levels & ~r_drive) == '0))
        else $error("level bit outside the driven bytes");
`endif

endmodule

FILE: hdl/lmbc_cell.sv
module lmbc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lmbc_pkg::t_cell_cmd i_cmd,
    input  logic               i_sel,
    input  lmbc_pkg::t_link    i_lo,
    input  lmbc_pkg::t_link    i_hi,
    output lmbc_pkg::t_link    o_link,
    output logic               o_lit
);
    import lmbc_pkg::*;

    logic [TIME_W-1:0] r_time, n_time;
    logic              r_slow, n_slow;
    logic              r_fast, n_fast;
    logic              r_first, n_first;
    t_link             r_link, n_link;
    t_link             w_in;

    // The rotation link arrives from the neighbour upstream of the scan.
    assign w_in = i_cmd.rot_down ? i_hi : i_lo;

    // Next state of the lamp held by this cell.
    always_comb begin
        n_time  = r_time;
        n_slow  = r_slow;
        n_fast  = r_fast;
        n_first = r_first;
        n_link  = w_in;

        case (i_cmd.time_op)
            T_SEL:   if (i_sel) n_time = i_cmd.time_val;
            T_ALL:   n_time = i_sel ? i_cmd.time_val : '0;
            default: ;
        endcase

        case (i_cmd.slow_op)
            B_SET:   if (i_sel) n_slow = 1'b1;
            B_CLR:   if (i_sel) n_slow = 1'b0;
            B_ZERO:  n_slow = 1'b0;
            default: ;
        endcase

        case (i_cmd.fast_op)
            B_SET:   if (i_sel) n_fast = 1'b1;
            B_CLR:   if (i_sel) n_fast = 1'b0;
            B_ZERO:  n_fast = 1'b0;
            default: ;
        endcase

        if (i_cmd.rot_clr) begin
            n_first = 1'b0;
        end

        // A selected lamp swaps its on-time with the travelling carry; the
        // first selected lamp of the scan only loads the carry.
        if (w_in.tok && i_sel) begin
            n_link.carry = r_time;
            n_link.cv    = 1'b1;
            if (w_in.cv) begin
                n_time = w_in.carry;
            end else begin
                n_first = 1'b1;
            end
        end

        // The last carry of the scan closes the circle at the first lamp.
        if (i_cmd.wrap && r_first) begin
            n_time = i_cmd.wrap_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time  <= '0;
            r_slow  <= 1'b1;
            r_fast  <= 1'b0;
            r_first <= 1'b0;
            r_link  <= '0;
        end else begin
            r_time  <= n_time;
            r_slow  <= n_slow;
            r_fast  <= n_fast;
            r_first <= n_first;
            r_link  <= n_link;
        end
    end

    assign o_link = r_link;

    // Lamp is lit while its on-time exceeds the count or its blink phase is on.
    assign o_lit = (r_time > i_cmd.now)
                 | (i_cmd.slow_phase & r_slow)
                 | (i_cmd.fast_phase & r_fast);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lmbc_pkg::*;

    localparam int NUM_LAMPS    = 32;
    localparam int NUM_WINGS    = 4;
    localparam int N_PHASES     = 8;
    localparam int ITEMS_PER_PH = 141;
    localparam int SETTLE       = NUM_LAMPS + 8;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;

    // One lamp command or refresh as offered on the input channel.
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [MASK_W-1:0] mask;
        logic              flag_on;
        logic              flag_slow;
        logic              flag_fast;
        logic [IDX_W-1:0]  index;
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] now_us;
        logic              sph;
        logic              fph;
    } t_lamp_cmd;

    // Pin values produced by one item.
    typedef struct packed {
        logic [MASK_W-1:0] levels;
        logic [MASK_W-1:0] drive;
    } t_pins;

    // Mirror of the lamp bank: on-times, blink sets and board configuration.
    class lamp_bank_scoreboard;
        logic [TIME_W-1:0] on_time [NUM_LAMPS];
        logic [MASK_W-1:0] slow_set;
        logic [MASK_W-1:0] fast_set;
        logic [WING_W-1:0] wing_valid;
        logic [WING_W-1:0] wing_invert;
        logic              out_en;
        t_pins             pins_q[$];
        int                errors;
        int                n_items;
        int                n_checked;
        int                n_lit;
        int                n_rotations;

        function new();
            foreach (on_time[i]) on_time[i] = '0;
            slow_set    = '1;
            fast_set    = '0;
            wing_valid  = '0;
            wing_invert = '0;
            out_en      = 1'b0;
            errors      = 0;
            n_items     = 0;
            n_checked   = 0;
            n_lit       = 0;
            n_rotations = 0;
        endfunction

        function void set_config(logic [WING_W-1:0] valid, logic [WING_W-1:0] inv,
                                 logic en);
            wing_valid  = valid;
            wing_invert = inv;
            out_en      = en;
        endfunction

        function void write_masked(logic [MASK_W-1:0] m, logic [TIME_W-1:0] v);
            for (int i = 0; i < NUM_LAMPS; i++)
                if (m[i]) on_time[i] = v;
        endfunction

        // Masked lamps join one blink set, leave the other and go dark.
        function void join_blink(logic [MASK_W-1:0] m, bit to_slow);
            if (to_slow) begin
                slow_set |= m;
                fast_set &= ~m;
            end else begin
                fast_set |= m;
                slow_set &= ~m;
            end
            write_masked(m, '0);
        endfunction

        // Circular move of on-times among the masked lamps only.
        function void rotate_times(logic [MASK_W-1:0] m, bit downward);
            int                first;
            int                i;
            logic [TIME_W-1:0] carry;
            logic [TIME_W-1:0] t;
            first = -1;
            carry = '0;
            for (int k = 0; k < NUM_LAMPS; k++) begin
                i = downward ? (NUM_LAMPS - 1 - k) : k;
                if (m[i]) begin
                    if (first < 0) begin
                        first = i;
                        carry = on_time[i];
                    end else begin
                        t          = on_time[i];
                        on_time[i] = carry;
                        carry      = t;
                    end
                end
            end
            if (first >= 0) on_time[first] = carry;
        endfunction

        // Apply an accepted transfer and queue the pins it must produce.
        function void note_item(t_lamp_cmd c);
            t_pins             p;
            logic [MASK_W-1:0] lit;
            logic [BYTE_W-1:0] b;
            p = '0;
            n_items++;
            case (c.func)
                F_REFRESH: begin
                    if (out_en && wing_valid != '0) begin
                        lit = (c.sph ? slow_set : '0) | (c.fph ? fast_set : '0);
                        for (int i = 0; i < NUM_LAMPS; i++)
                            if (on_time[i] > c.now_us) lit[i] = 1'b1;
                        for (int w = 0; w < NUM_WINGS; w++) begin
                            if (wing_valid[w]) begin
                                b = lit[w*BYTE_W +: BYTE_W];
                                if (wing_invert[w]) b = ~b;
                                p.levels[w*BYTE_W +: BYTE_W] = b;
                                p.drive[w*BYTE_W +: BYTE_W]  = BYTE_MASK;
                            end
                        end
                        n_lit++;
                    end
                end
                F_ROT_LEFT: begin
                    rotate_times(c.mask, 1'b1);
                    n_rotations++;
                end
                F_ROT_RIGHT: begin
                    rotate_times(c.mask, 1'b0);
                    n_rotations++;
                end
                F_ON:  write_masked(c.mask, ON_TIME_US);
                F_OFF: write_masked(c.mask, '0);
                F_SLOW: join_blink(c.mask, 1'b1);
                F_FAST: join_blink(c.mask, 1'b0);
                F_BLINK_OFF: begin
                    slow_set &= ~c.mask;
                    fast_set &= ~c.mask;
                end
                F_SET_ONOFF: begin
                    for (int i = 0; i < NUM_LAMPS; i++)
                        on_time[i] = c.mask[i] ? ON_TIME_US : '0;
                    slow_set = '0;
                    fast_set = '0;
                end
                F_COMBINED: begin
                    write_masked(c.mask, c.flag_on ? ON_TIME_US : '0);
                    if (c.flag_slow) begin
                        join_blink(c.mask, 1'b1);
                    end else if (c.flag_fast) begin
                        join_blink(c.mask, 1'b0);
                    end else begin
                        slow_set &= ~c.mask;
                        fast_set &= ~c.mask;
                    end
                end
                F_SET_DUR: on_time[c.index] = c.dur;
                default: ;
            endcase
            pins_q.push_back(p);
        endfunction

        task report(string msg);
            errors++;
            $display("tb: mismatch at %0t: %s", $realtime, msg);
        endtask

        // Compare a result transfer with the oldest queued pins.
        task check_pins(logic [MASK_W-1:0] levels, logic [MASK_W-1:0] drive);
            t_pins p;
            if (pins_q.size() == 0) begin
                report($sformatf("result %h/%h with nothing expected", levels, drive));
            end else begin
                p = pins_q.pop_front();
                n_checked++;
                if (levels !== p.levels)
                    report($sformatf("lamp_levels %h, expected %h", levels, p.levels));
                if (drive !== p.drive)
                    report($sformatf("drive_mask %h, expected %h", drive, p.drive));
            end
        endtask
    endclass

    // Block inputs start at known values.
    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx         = '0;
    logic [WING_W-1:0]    i_cfg_data        = '0;
    logic                 i_valid           = 1'b0;
    logic [FUNC_W-1:0]    i_func            = '0;
    logic [MASK_W-1:0]    i_lamp_mask       = '0;
    logic                 i_flag_on         = 1'b0;
    logic                 i_flag_blink_slow = 1'b0;
    logic                 i_flag_blink_fast = 1'b0;
    logic [IDX_W-1:0]     i_lamp_index      = '0;
    logic [TIME_W-1:0]    i_duration        = '0;
    logic [TIME_W-1:0]    i_now_us          = '0;
    logic                 i_slow_phase      = 1'b0;
    logic                 i_fast_phase      = 1'b0;
    logic                 i_ready           = 1'b0;
    logic                 o_ready;
    logic                 o_valid;
    logic [MASK_W-1:0]    o_lamp_levels;
    logic [MASK_W-1:0]    o_drive_mask;

    lamp_bank_scoreboard sb;
    bit                  quiet     = 1'b0;
    bit                  hold_done = 1'b0;
    int                  hold_left = 0;
    int                  rx_stall  = 0;
    int                  n_cfg     = 0;

    masked_lamp_bank_controller #(
        .NUM_LAMPS(NUM_LAMPS),
        .NUM_WINGS(NUM_WINGS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_func(i_func),
        .i_lamp_mask(i_lamp_mask),
        .i_flag_on(i_flag_on),
        .i_flag_blink_slow(i_flag_blink_slow),
        .i_flag_blink_fast(i_flag_blink_fast),
        .i_lamp_index(i_lamp_index),
        .i_duration(i_duration),
        .i_now_us(i_now_us),
        .i_slow_phase(i_slow_phase),
        .i_fast_phase(i_fast_phase),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_lamp_levels(o_lamp_levels),
        .o_drive_mask(o_drive_mask)
    );

    always #6 i_clk = ~i_clk;

    // Watch both channels; input transfers are noted before results are checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_item('{i_func, i_lamp_mask, i_flag_on, i_flag_blink_slow,
                               i_flag_blink_fast, i_lamp_index, i_duration, i_now_us,
                               i_slow_phase, i_fast_phase});
            if (o_valid && i_ready)
                sb.check_pins(o_lamp_levels, o_drive_mask);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!hold_done && sb.n_items >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) rx_stall <= $urandom_range(1, 10);
        end
    end

    // Offer one item, hold it until the transfer, then perhaps idle for a burst.
    task send_item(t_lamp_cmd c);
        i_valid           <= 1'b1;
        i_func            <= c.func;
        i_lamp_mask       <= c.mask;
        i_flag_on         <= c.flag_on;
        i_flag_blink_slow <= c.flag_slow;
        i_flag_blink_fast <= c.flag_fast;
        i_lamp_index      <= c.index;
        i_duration        <= c.dur;
        i_now_us          <= c.now_us;
        i_slow_phase      <= c.sph;
        i_fast_phase      <= c.fph;
        do @(posedge i_clk); while (!o_ready);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task send_cmd(logic [FUNC_W-1:0] f, logic [MASK_W-1:0] m);
        t_lamp_cmd c;
        c      = '0;
        c.func = f;
        c.mask = m;
        send_item(c);
    endtask

    task send_refresh(logic [TIME_W-1:0] now_us, logic sph, logic fph);
        t_lamp_cmd c;
        c        = '0;
        c.func   = F_REFRESH;
        c.now_us = now_us;
        c.sph    = sph;
        c.fph    = fph;
        send_item(c);
    endtask

    task send_combined(logic [MASK_W-1:0] m, logic on, logic slow, logic fast);
        t_lamp_cmd c;
        c           = '0;
        c.func      = F_COMBINED;
        c.mask      = m;
        c.flag_on   = on;
        c.flag_slow = slow;
        c.flag_fast = fast;
        send_item(c);
    endtask

    task send_duration(logic [IDX_W-1:0] idx, logic [TIME_W-1:0] dur);
        t_lamp_cmd c;
        c       = '0;
        c.func  = F_SET_DUR;
        c.index = idx;
        c.dur   = dur;
        send_item(c);
    endtask

    // Writes all three registers on consecutive edges; the block is idle here.
    task apply_config(logic [WING_W-1:0] valid, logic [WING_W-1:0] inv, logic en);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_WING_VALID;
        i_cfg_data <= valid;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_WING_INVERT;
        i_cfg_data <= inv;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OUT_EN;
        i_cfg_data <= WING_W'(en);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_config(valid, inv, en);
        n_cfg++;
    endtask

    // Stop offering and wait until every queued result has come back. The
    // first edge lets the monitor note the last transfer before the queue is read.
    task drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pins_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [MASK_W-1:0] rand_mask();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return '0;
            1: return '1;
            2: return MASK_W'(1) << $urandom_range(0, NUM_LAMPS - 1);
            3, 4: return $urandom & $urandom;
            5: return (MASK_W'(1) << $urandom_range(0, NUM_LAMPS - 1)) |
                      (MASK_W'(1) << $urandom_range(0, NUM_LAMPS - 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        int r;
        r = $urandom_range(0, 7);
        if (r < 3) return TIME_W'($urandom_range(900, 1100));
        if (r < 5) return TIME_W'($urandom_range(0, 2000));
        if (r == 5) return $urandom_range(0, 1) ? '1 : '0;
        return TIME_W'($urandom);
    endfunction

    // Mostly refreshes and lamp commands with random content, a few unused codes.
    function automatic t_lamp_cmd rand_cmd();
        t_lamp_cmd c;
        int        r;
        r           = $urandom_range(0, 99);
        c.mask      = rand_mask();
        c.flag_on   = 1'($urandom_range(0, 1));
        c.flag_slow = 1'($urandom_range(0, 1));
        c.flag_fast = 1'($urandom_range(0, 1));
        c.index     = IDX_W'($urandom);
        c.dur       = rand_time();
        c.now_us    = rand_time();
        c.sph       = 1'($urandom_range(0, 1));
        c.fph       = 1'($urandom_range(0, 1));
        if (r < 35)      c.func = F_REFRESH;
        else if (r < 43) c.func = F_ROT_LEFT;
        else if (r < 51) c.func = F_ROT_RIGHT;
        else if (r < 57) c.func = F_ON;
        else if (r < 62) c.func = F_OFF;
        else if (r < 67) c.func = F_SLOW;
        else if (r < 72) c.func = F_FAST;
        else if (r < 76) c.func = F_BLINK_OFF;
        else if (r < 79) c.func = F_SET_ONOFF;
        else if (r < 87) c.func = F_COMBINED;
        else if (r < 98) c.func = F_SET_DUR;
        else             c.func = FUNC_W'(F_SET_DUR + $urandom_range(1, 5));
        return c;
    endfunction

    // Wing valid, wing invert and enable for each random phase.
    logic [WING_W-1:0] ph_valid [N_PHASES] = '{4'hf, 4'hf, 4'h0, 4'hf,
                                              4'h5, 4'h0, 4'ha, 4'hf};
    logic [WING_W-1:0] ph_inv   [N_PHASES] = '{4'h0, 4'hf, 4'hf, 4'h0,
                                              4'ha, 4'h0, 4'h5, 4'h0};
    logic              ph_en    [N_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0,
                                              1'b1, 1'b1, 1'b1, 1'b1};

    initial begin
        logic [WING_W-1:0] v;
        logic [WING_W-1:0] inv;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        apply_config(4'hf, 4'h0, 1'b1);

        // Directed: reset blink state, on-time edges, every command, flag priority.
        send_refresh('0, 1'b1, 1'b0);
        send_refresh('0, 1'b0, 1'b1);
        send_cmd(F_SET_ONOFF, '1);
        send_refresh(16'd999, 1'b0, 1'b0);
        send_refresh(16'd1000, 1'b1, 1'b1);
        send_duration(5'd0, '1);
        send_duration(5'd31, 16'd1);
        send_refresh(16'hfffe, 1'b0, 1'b0);
        send_cmd(F_ROT_LEFT, 32'h8000_0001);
        send_cmd(F_ROT_RIGHT, 32'ha5a5_a5a5);
        send_cmd(F_ROT_LEFT, '0);
        send_cmd(F_ROT_RIGHT, 32'h0000_0100);
        send_cmd(F_OFF, 32'h0000_ffff);
        send_cmd(F_SLOW, 32'h0f0f_0f0f);
        send_cmd(F_FAST, 32'hf0f0_f0f0);
        send_cmd(F_BLINK_OFF, 32'h00ff_00ff);
        send_refresh(16'd500, 1'b1, 1'b1);
        send_combined(32'h0000_00ff, 1'b1, 1'b1, 1'b1);
        send_combined(32'h0000_ff00, 1'b0, 1'b0, 1'b1);
        send_combined(32'h00ff_0000, 1'b1, 1'b0, 1'b0);
        send_combined(32'hff00_0000, 1'b0, 1'b0, 1'b0);
        send_cmd(F_ON, 32'hffff_0000);
        send_cmd(FUNC_W'(F_SET_DUR + 5), '1);
        send_refresh('0, 1'b1, 1'b1);
        send_refresh('1, 1'b1, 1'b0);
        drain();

        // Random phases, each under its own board configuration; the last has no idling.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            v   = ph_valid[ph];
            inv = ph_inv[ph];
            if (ph == 5) begin
                v   = WING_W'($urandom);
                inv = WING_W'($urandom);
            end
            if (ph == N_PHASES - 1) begin
                inv   = WING_W'($urandom);
                quiet = 1'b1;
            end
            apply_config(v, inv, ph_en[ph]);
            for (int n = 0; n < ITEMS_PER_PH; n++) send_item(rand_cmd());
            drain();
        end

        $display("tb: %0d items sent, %0d results compared, %0d refreshes drove pins",
                 sb.n_items, sb.n_checked, sb.n_lit);
        $display("tb: %0d rotations, %0d board settings, one long receiver hold-off",
                 sb.n_rotations, n_cfg);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #4_800_000;
        $display("tb: failure");
        $finish;
    end

endmodule
